### design/dlt_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Drawing-language tokenizer package
// Shared types, token codes, character codes and the keyword table.
// ----------------------------------------------------------------------------
package dlt_pkg;

    localparam int MAX_TOKEN_CHARS_DEF     = 19;
    localparam int FRAC_BITS_DEF           = 16;
    localparam int MAX_FRACTION_DIGITS_DEF = 9;

    localparam int NAME_DEPTH = 6;
    localparam int NAME_IDX_W = $clog2(NAME_DEPTH);
    localparam int COUNT_W    = 5;
    localparam int VALUE_W    = 48;
    localparam int NUM_WORDS  = 18;

    // Token kinds.
    localparam logic [4:0] K_END    = 5'd0;
    localparam logic [4:0] K_ERR    = 5'd1;
    localparam logic [4:0] K_CONST  = 5'd2;
    localparam logic [4:0] K_PARAM  = 5'd3;
    localparam logic [4:0] K_FUNC   = 5'd4;
    localparam logic [4:0] K_ORIGIN = 5'd5;
    localparam logic [4:0] K_SCALE  = 5'd6;
    localparam logic [4:0] K_ROT    = 5'd7;
    localparam logic [4:0] K_IS     = 5'd8;
    localparam logic [4:0] K_FOR    = 5'd9;
    localparam logic [4:0] K_FROM   = 5'd10;
    localparam logic [4:0] K_TO     = 5'd11;
    localparam logic [4:0] K_STEP   = 5'd12;
    localparam logic [4:0] K_DRAW   = 5'd13;
    localparam logic [4:0] K_SEMI   = 5'd14;
    localparam logic [4:0] K_LPAREN = 5'd15;
    localparam logic [4:0] K_RPAREN = 5'd16;
    localparam logic [4:0] K_COMMA  = 5'd17;
    localparam logic [4:0] K_PLUS   = 5'd18;
    localparam logic [4:0] K_MINUS  = 5'd19;
    localparam logic [4:0] K_MUL    = 5'd20;
    localparam logic [4:0] K_DIV    = 5'd21;
    localparam logic [4:0] K_POW    = 5'd22;

    // Function identifiers.
    localparam logic [2:0] F_SIN  = 3'd0;
    localparam logic [2:0] F_COS  = 3'd1;
    localparam logic [2:0] F_TAN  = 3'd2;
    localparam logic [2:0] F_LOG  = 3'd3;
    localparam logic [2:0] F_EXP  = 3'd4;
    localparam logic [2:0] F_SQRT = 3'd5;

    // Character codes.
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;

    typedef enum logic [2:0] {
        SC_START,
        SC_WORD,
        SC_NUM,
        SC_STAR,
        SC_SLASH,
        SC_MINUS,
        SC_COMMENT
    } t_scan;

    typedef enum logic [2:0] {
        CS_IDLE,
        CS_MAIN,
        CS_DIV,
        CS_START,
        CS_END
    } t_ctl_state;

    typedef enum logic [1:0] {
        SRC_MAIN,
        SRC_NUM,
        SRC_START,
        SRC_END
    } t_src;

    typedef struct packed {
        logic accept;
        logic main;
        logic start;
        logic div_start;
        logic load;
        t_src src;
        logic last;
    } t_cmd;

    typedef struct packed {
        logic eoi;
        logic main_emit;
        logic main_num;
        logic main_again;
        logic start_emit;
        logic slot_free;
        logic div_busy;
    } t_stat;

    typedef struct packed {
        logic [4:0] kind;
        logic [2:0] func;
        logic       is_pi;
        logic       is_e;
    } t_word_hit;

    // Keyword table; text is left aligned and padded with spaces.
    localparam logic [47:0] WORD_TEXT [NUM_WORDS] = '{
        "PI    ", "E     ", "T     ", "SIN   ", "COS   ", "TAN   ",
        "LOG   ", "EXP   ", "SQRT  ", "ORIGIN", "SCALE ", "ROT   ",
        "IS    ", "FOR   ", "FROM  ", "TO    ", "STEP  ", "DRAW  "
    };
    localparam logic [4:0] WORD_LEN [NUM_WORDS] = '{
        5'd2, 5'd1, 5'd1, 5'd3, 5'd3, 5'd3, 5'd3, 5'd3, 5'd4,
        5'd6, 5'd5, 5'd3, 5'd2, 5'd3, 5'd4, 5'd2, 5'd4, 5'd4
    };
    localparam logic [4:0] WORD_KIND [NUM_WORDS] = '{
        K_CONST, K_CONST, K_PARAM, K_FUNC, K_FUNC, K_FUNC, K_FUNC, K_FUNC, K_FUNC,
        K_ORIGIN, K_SCALE, K_ROT, K_IS, K_FOR, K_FROM, K_TO, K_STEP, K_DRAW
    };
    localparam logic [2:0] WORD_FUNC [NUM_WORDS] = '{
        F_SIN, F_COS, F_SIN, F_SIN, F_COS, F_TAN, F_LOG, F_EXP, F_SQRT,
        F_SIN, F_SIN, F_SIN, F_SIN, F_SIN, F_SIN, F_SIN, F_SIN, F_SIN
    };

    function automatic logic is_letter(input logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic logic [7:0] to_upper(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7A) ? c - 8'd32 : c;
    endfunction

    function automatic logic [29:0] pow10(input logic [3:0] d);
        logic [29:0] p;
        unique case (d)
            4'd0:    p = 30'd1;
            4'd1:    p = 30'd10;
            4'd2:    p = 30'd100;
            4'd3:    p = 30'd1000;
            4'd4:    p = 30'd10000;
            4'd5:    p = 30'd100000;
            4'd6:    p = 30'd1000000;
            4'd7:    p = 30'd10000000;
            4'd8:    p = 30'd100000000;
            4'd9:    p = 30'd1000000000;
            default: p = 30'd1;
        endcase
        return p;
    endfunction

    // The name is packed with its first character in the low byte.
    function automatic t_word_hit word_lookup(input logic [8*NAME_DEPTH-1:0] name,
                                              input logic [COUNT_W-1:0] count);
        t_word_hit h;
        logic      match;
        h = '{kind: K_ERR, func: 3'd0, is_pi: 1'b0, is_e: 1'b0};
        for (int e = 0; e < NUM_WORDS; e++) begin
            match = (count == WORD_LEN[e]);
            for (int i = 0; i < NAME_DEPTH; i++) begin
                if (5'(i) < WORD_LEN[e] && name[8*i +: 8] != WORD_TEXT[e][47-8*i -: 8]) begin
                    match = 1'b0;
                end
            end
            if (match) begin
                h.kind  = WORD_KIND[e];
                h.func  = (WORD_KIND[e] == K_FUNC) ? WORD_FUNC[e] : 3'd0;
                h.is_pi = (WORD_KIND[e] == K_CONST) && (WORD_FUNC[e] == F_SIN);
                h.is_e  = (WORD_KIND[e] == K_CONST) && (WORD_FUNC[e] == F_COS);
            end
        end
        return h;
    endfunction

endpackage
`default_nettype wire

### design/dlt_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Fraction divider
// Restoring divider, one quotient bit per cycle, that turns the decimal
// fraction digits into binary fraction bits and adds the integer part.
// ----------------------------------------------------------------------------
module dlt_div #(
    parameter int FracBits = dlt_pkg::FRAC_BITS_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_start,
    input  wire logic [29:0]                 i_frac,
    input  wire logic [3:0]                  i_fdig,
    input  wire logic [31:0]                 i_int,
    output logic                             o_busy,
    output logic [dlt_pkg::VALUE_W-1:0]      o_value
);
    import dlt_pkg::*;

    localparam int DqW  = 30 + FracBits;
    localparam int ValW = 32 + FracBits;
    localparam int CntW = $clog2(DqW + 1);

    logic [DqW-1:0]  r_dq;
    logic [29:0]     r_rem;
    logic [29:0]     r_dsor;
    logic [31:0]     r_int;
    logic [CntW-1:0] r_cnt;

    logic [30:0]          trial;
    logic [30:0]          diff;
    logic                 ge;
    logic [ValW-1:0]      full;
    logic [ValW+VALUE_W-1:0] full_ext;

    assign trial    = {r_rem, r_dq[DqW-1]};
    assign diff     = trial - {1'b0, r_dsor};
    assign ge       = trial >= {1'b0, r_dsor};
    assign o_busy   = (r_cnt != '0);
    assign full     = {r_int, {FracBits{1'b0}}} + ValW'(r_dq);
    assign full_ext = {{VALUE_W{1'b0}}, full};
    assign o_value  = full_ext[VALUE_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= CntW'(DqW);
        end else if (o_busy) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dq   <= {i_frac, {FracBits{1'b0}}};
            r_rem  <= '0;
            r_dsor <= pow10(i_fdig);
            r_int  <= i_int;
        end else if (o_busy) begin
            r_rem <= ge ? diff[29:0] : trial[29:0];
            r_dq  <= {r_dq[DqW-2:0], ge};
        end
    end

endmodule
`default_nettype wire

### design/dlt_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Tokenizer datapath
// Scanner state, name buffer, number accumulators, divider and output stage.
// ----------------------------------------------------------------------------
module dlt_dp #(
    parameter int MaxTokenChars     = dlt_pkg::MAX_TOKEN_CHARS_DEF,
    parameter int FracBits          = dlt_pkg::FRAC_BITS_DEF,
    parameter int MaxFractionDigits = dlt_pkg::MAX_FRACTION_DIGITS_DEF
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire dlt_pkg::t_cmd           i_cmd,
    output dlt_pkg::t_stat               o_stat,
    input  wire logic [7:0]              i_ch,
    input  wire logic                    i_end_of_input,
    input  wire logic                    i_ready,
    output logic                         o_valid,
    output logic [4:0]                   o_token_kind,
    output logic [2:0]                   o_func_id,
    output logic [dlt_pkg::VALUE_W-1:0]  o_token_value,
    output logic                         o_last
);
    import dlt_pkg::*;

    localparam int ValW = 32 + FracBits;
    localparam logic [ValW-1:0] PiFix = ValW'((64'd3 << FracBits) +
                                              ((64'd1415926 << FracBits) / 64'd10000000));
    localparam logic [ValW-1:0] EFix  = ValW'((64'd2 << FracBits) +
                                              ((64'd71828 << FracBits) / 64'd100000));
    localparam logic [ValW+VALUE_W-1:0] PiExt = {{VALUE_W{1'b0}}, PiFix};
    localparam logic [ValW+VALUE_W-1:0] EExt  = {{VALUE_W{1'b0}}, EFix};
    localparam logic [VALUE_W-1:0] PiVal = PiExt[VALUE_W-1:0];
    localparam logic [VALUE_W-1:0] EVal  = EExt[VALUE_W-1:0];

    logic [7:0]         r_ch;
    logic               r_eoi;
    t_scan              r_scan, n_scan;
    logic [7:0]         r_buf [NAME_DEPTH];
    logic [COUNT_W-1:0] r_count, n_count;
    logic               r_seen, n_seen;
    logic [31:0]        r_int, n_int;
    logic [29:0]        r_frac, n_frac;
    logic [3:0]         r_fdig, n_fdig;
    logic               r_out_valid;
    logic [4:0]         r_kind;
    logic [2:0]         r_func;
    logic [VALUE_W-1:0] r_value;
    logic               r_last;

    // Main-phase results.
    t_scan              m_scan;
    logic [COUNT_W-1:0] m_count;
    logic               m_seen;
    logic [31:0]        m_int;
    logic [29:0]        m_frac;
    logic [3:0]         m_fdig;
    logic               m_we;
    logic               m_emit, m_num, m_again;
    logic [4:0]         m_kind;
    logic [2:0]         m_func;
    logic [VALUE_W-1:0] m_value;

    // Start-phase results.
    t_scan              s_scan;
    logic [COUNT_W-1:0] s_count;
    logic [31:0]        s_int;
    logic [29:0]        s_frac;
    logic [3:0]         s_fdig;
    logic               s_we;
    logic               s_emit;
    logic [4:0]         s_kind;

    logic                    ch_letter, ch_digit, ch_dot;
    logic [3:0]              ch_val;
    logic [7:0]              ch_up;
    logic [8*NAME_DEPTH-1:0] name_flat;
    t_word_hit               hit;
    logic [VALUE_W-1:0]      word_value;
    logic [35:0]             int_mul;
    logic                    div_busy;
    logic [VALUE_W-1:0]      div_value;

    assign ch_letter = is_letter(r_ch);
    assign ch_digit  = is_digit(r_ch);
    assign ch_dot    = (r_ch == CH_DOT);
    assign ch_val    = r_ch[3:0];
    assign ch_up     = to_upper(r_ch);
    assign int_mul   = {4'd0, r_int} * 36'd10 + {32'd0, ch_val};

    always_comb begin
        for (int i = 0; i < NAME_DEPTH; i++) begin
            name_flat[8*i +: 8] = r_buf[i];
        end
    end

    assign hit        = word_lookup(name_flat, r_count);
    assign word_value = hit.is_pi ? PiVal : (hit.is_e ? EVal : '0);

    // Work on the pending token with the current character.
    always_comb begin
        m_scan  = r_scan;
        m_count = r_count;
        m_seen  = r_seen;
        m_int   = r_int;
        m_frac  = r_frac;
        m_fdig  = r_fdig;
        m_we    = 1'b0;
        m_emit  = 1'b0;
        m_num   = 1'b0;
        m_again = 1'b0;
        m_kind  = K_ERR;
        m_func  = 3'd0;
        m_value = '0;
        if (r_eoi) begin
            unique case (r_scan)
                SC_WORD: begin
                    m_emit  = 1'b1;
                    m_kind  = hit.kind;
                    m_func  = hit.func;
                    m_value = word_value;
                end
                SC_NUM: begin
                    m_emit = 1'b1;
                    m_num  = 1'b1;
                    m_kind = K_CONST;
                end
                SC_STAR: begin
                    m_emit = 1'b1;
                    m_kind = K_MUL;
                end
                SC_SLASH: begin
                    m_emit = 1'b1;
                    m_kind = K_DIV;
                end
                SC_MINUS: begin
                    m_emit = 1'b1;
                    m_kind = K_MINUS;
                end
                default: begin
                end
            endcase
            m_scan  = SC_START;
            m_count = '0;
            m_seen  = 1'b0;
        end else begin
            unique case (r_scan)
                SC_WORD: begin
                    if (ch_letter || ch_digit) begin
                        if (r_count >= COUNT_W'(MaxTokenChars)) begin
                            m_emit  = 1'b1;
                            m_again = 1'b1;
                        end else begin
                            m_we    = (r_count < COUNT_W'(NAME_DEPTH));
                            m_count = r_count + 1'b1;
                        end
                    end else begin
                        m_emit  = 1'b1;
                        m_again = 1'b1;
                        m_kind  = hit.kind;
                        m_func  = hit.func;
                        m_value = word_value;
                    end
                end
                SC_NUM: begin
                    if (ch_digit || ch_dot) begin
                        if (ch_dot && r_seen) begin
                            m_emit = 1'b1;
                            m_scan = SC_START;
                        end else if (r_count >= COUNT_W'(MaxTokenChars)) begin
                            m_emit  = 1'b1;
                            m_again = 1'b1;
                        end else begin
                            m_count = r_count + 1'b1;
                            if (ch_dot) begin
                                m_seen = 1'b1;
                            end else if (r_seen) begin
                                if (r_fdig < 4'(MaxFractionDigits)) begin
                                    m_frac = 30'(r_frac * 30'd10 + {26'd0, ch_val});
                                    m_fdig = r_fdig + 1'b1;
                                end
                            end else begin
                                m_int = (int_mul[35:32] != 4'd0) ? 32'hFFFF_FFFF
                                                                 : int_mul[31:0];
                            end
                        end
                    end else begin
                        m_emit  = 1'b1;
                        m_num   = 1'b1;
                        m_again = 1'b1;
                        m_kind  = K_CONST;
                    end
                end
                SC_STAR: begin
                    m_emit = 1'b1;
                    if (r_ch == CH_STAR) begin
                        m_kind = K_POW;
                        m_scan = SC_START;
                    end else begin
                        m_kind  = K_MUL;
                        m_again = 1'b1;
                    end
                end
                SC_SLASH: begin
                    if (r_ch == CH_SLASH) begin
                        m_scan = SC_COMMENT;
                    end else begin
                        m_emit  = 1'b1;
                        m_kind  = K_DIV;
                        m_again = 1'b1;
                    end
                end
                SC_MINUS: begin
                    if (r_ch == CH_MINUS) begin
                        m_scan = SC_COMMENT;
                    end else begin
                        m_emit  = 1'b1;
                        m_kind  = K_MINUS;
                        m_again = 1'b1;
                    end
                end
                SC_COMMENT: begin
                    if (r_ch == CH_LF) begin
                        m_scan = SC_START;
                    end
                end
                default: begin
                    m_again = 1'b1;
                end
            endcase
        end
    end

    // Begin a fresh token with the current character.
    always_comb begin
        s_scan  = SC_START;
        s_count = '0;
        s_int   = r_int;
        s_frac  = r_frac;
        s_fdig  = r_fdig;
        s_we    = 1'b0;
        s_emit  = 1'b0;
        s_kind  = K_ERR;
        priority if (ch_letter) begin
            s_scan  = SC_WORD;
            s_count = COUNT_W'(1);
            s_we    = 1'b1;
        end else if (ch_digit) begin
            s_scan  = SC_NUM;
            s_count = COUNT_W'(1);
            s_int   = {28'd0, ch_val};
            s_frac  = '0;
            s_fdig  = '0;
        end else begin
            unique case (r_ch)
                CH_STAR:   s_scan = SC_STAR;
                CH_SLASH:  s_scan = SC_SLASH;
                CH_MINUS:  s_scan = SC_MINUS;
                CH_SEMI:   begin s_emit = 1'b1; s_kind = K_SEMI;   end
                CH_LPAREN: begin s_emit = 1'b1; s_kind = K_LPAREN; end
                CH_RPAREN: begin s_emit = 1'b1; s_kind = K_RPAREN; end
                CH_COMMA:  begin s_emit = 1'b1; s_kind = K_COMMA;  end
                CH_PLUS:   begin s_emit = 1'b1; s_kind = K_PLUS;   end
                CH_SPACE, CH_TAB, CH_LF, CH_CR: begin
                end
                default:   s_emit = 1'b1;
            endcase
        end
    end

    always_comb begin
        n_scan  = r_scan;
        n_count = r_count;
        n_seen  = r_seen;
        n_int   = r_int;
        n_frac  = r_frac;
        n_fdig  = r_fdig;
        if (i_cmd.main) begin
            n_scan  = m_scan;
            n_count = m_count;
            n_seen  = m_seen;
            n_int   = m_int;
            n_frac  = m_frac;
            n_fdig  = m_fdig;
        end else if (i_cmd.start) begin
            n_scan  = s_scan;
            n_count = s_count;
            n_seen  = 1'b0;
            n_int   = s_int;
            n_frac  = s_frac;
            n_fdig  = s_fdig;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan      <= SC_START;
            r_count     <= '0;
            r_seen      <= 1'b0;
            r_int       <= '0;
            r_frac      <= '0;
            r_fdig      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_scan  <= n_scan;
            r_count <= n_count;
            r_seen  <= n_seen;
            r_int   <= n_int;
            r_frac  <= n_frac;
            r_fdig  <= n_fdig;
            if (i_cmd.load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_ch  <= i_ch;
            r_eoi <= i_end_of_input;
        end
        if (i_cmd.main && m_we) begin
            r_buf[r_count[NAME_IDX_W-1:0]] <= ch_up;
        end else if (i_cmd.start && s_we) begin
            r_buf[0] <= ch_up;
        end
        if (i_cmd.load) begin
            r_last <= i_cmd.last;
            unique case (i_cmd.src)
                SRC_MAIN: begin
                    r_kind  <= m_kind;
                    r_func  <= m_func;
                    r_value <= m_value;
                end
                SRC_NUM: begin
                    r_kind  <= K_CONST;
                    r_func  <= 3'd0;
                    r_value <= div_value;
                end
                SRC_START: begin
                    r_kind  <= s_kind;
                    r_func  <= 3'd0;
                    r_value <= '0;
                end
                SRC_END: begin
                    r_kind  <= K_END;
                    r_func  <= 3'd0;
                    r_value <= '0;
                end
                default: begin
                    r_kind  <= K_END;
                    r_func  <= 3'd0;
                    r_value <= '0;
                end
            endcase
        end
    end

    dlt_div #(
        .FracBits (FracBits)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_frac  (r_frac),
        .i_fdig  (r_fdig),
        .i_int   (r_int),
        .o_busy  (div_busy),
        .o_value (div_value)
    );

    assign o_stat = '{
        eoi:        r_eoi,
        main_emit:  m_emit,
        main_num:   m_num,
        main_again: m_again,
        start_emit: s_emit,
        slot_free:  !r_out_valid || i_ready,
        div_busy:   div_busy
    };

    assign o_valid       = r_out_valid;
    assign o_token_kind  = r_kind;
    assign o_func_id     = r_func;
    assign o_token_value = r_value;
    assign o_last        = r_last;

endmodule
`default_nettype wire

### design/dlt_ctl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Tokenizer controller
// Sequences one character through its main phase, the optional fraction
// division, the restart phase and the end token.
// ----------------------------------------------------------------------------
module dlt_ctl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    output logic                o_ready,
    input  wire dlt_pkg::t_stat i_stat,
    output dlt_pkg::t_cmd       o_cmd
);
    import dlt_pkg::*;

    t_ctl_state r_state, n_state;
    logic       r_again, n_again;
    t_ctl_state main_after;
    t_ctl_state div_after;

    assign main_after = i_stat.eoi ? CS_END : (i_stat.main_again ? CS_START : CS_IDLE);
    assign div_after  = i_stat.eoi ? CS_END : (r_again ? CS_START : CS_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= CS_IDLE;
            r_again <= 1'b0;
        end else begin
            r_state <= n_state;
            r_again <= n_again;
        end
    end

    always_comb begin
        n_state = r_state;
        n_again = r_again;
        o_cmd   = '0;
        o_ready = 1'b0;
        unique case (r_state)
            CS_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = CS_MAIN;
                end
            end
            CS_MAIN: begin
                n_again = i_stat.main_again;
                if (i_stat.main_emit && i_stat.main_num) begin
                    o_cmd.div_start = 1'b1;
                    o_cmd.main      = 1'b1;
                    n_state         = CS_DIV;
                end else if (i_stat.main_emit) begin
                    if (i_stat.slot_free) begin
                        o_cmd.load = 1'b1;
                        o_cmd.src  = SRC_MAIN;
                        o_cmd.last = !i_stat.eoi &&
                                     !(i_stat.main_again && i_stat.start_emit);
                        o_cmd.main = 1'b1;
                        n_state    = main_after;
                    end
                end else begin
                    o_cmd.main = 1'b1;
                    n_state    = main_after;
                end
            end
            CS_DIV: begin
                if (!i_stat.div_busy && i_stat.slot_free) begin
                    o_cmd.load = 1'b1;
                    o_cmd.src  = SRC_NUM;
                    o_cmd.last = !i_stat.eoi && !(r_again && i_stat.start_emit);
                    n_state    = div_after;
                end
            end
            CS_START: begin
                if (i_stat.start_emit) begin
                    if (i_stat.slot_free) begin
                        o_cmd.load  = 1'b1;
                        o_cmd.src   = SRC_START;
                        o_cmd.last  = 1'b1;
                        o_cmd.start = 1'b1;
                        n_state     = CS_IDLE;
                    end
                end else begin
                    o_cmd.start = 1'b1;
                    n_state     = CS_IDLE;
                end
            end
            CS_END: begin
                if (i_stat.slot_free) begin
                    o_cmd.load = 1'b1;
                    o_cmd.src  = SRC_END;
                    o_cmd.last = 1'b1;
                    n_state    = CS_IDLE;
                end
            end
            default: begin
                n_state = CS_IDLE;
            end
        endcase
    end

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |-> i_stat.slot_free)
        else $error("output register loaded while still occupied");

    a_div_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.div_start |-> !i_stat.div_busy)
        else $error("divider restarted while busy");

    a_div_runs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.div_start |=> i_stat.div_busy)
        else $error("divider did not start");

endmodule
`default_nettype wire

### design/drawing_language_tokenizer_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Drawing-language tokenizer core
// Turns a stream of ASCII characters into tokens of a small drawing language.
// ----------------------------------------------------------------------------
// Input channel: one character per beat on i_ch, or an end-of-input beat with
// i_end_of_input high (i_ch is ignored then), under i_valid / o_ready.
// Output channel: one token per beat under o_valid / i_ready; o_last marks the
// final token caused by an input beat. A character that ends a pending token
// starts the next one, so one input beat may yield two output beats.
// Flow: the core works on one character at a time. A plain character
// passes through accept and the main phase, and through the start phase too
// when it also starts a new token. A number ending first runs the restoring
// fraction divider, which produces one quotient bit per cycle.
// When the receiver stalls, the single output register holds its token and
// the controller waits before loading the next one, which in turn holds off
// new input beats. Reset returns the scanner to its start state with no
// pending token and an empty output register.
// ----------------------------------------------------------------------------
module drawing_language_tokenizer_core #(
    parameter int MaxTokenChars     = dlt_pkg::MAX_TOKEN_CHARS_DEF,
    parameter int FracBits          = dlt_pkg::FRAC_BITS_DEF,
    parameter int MaxFractionDigits = dlt_pkg::MAX_FRACTION_DIGITS_DEF
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_valid,
    output logic                         o_ready,
    input  wire logic [7:0]              i_ch,
    input  wire logic                    i_end_of_input,
    output logic                         o_valid,
    input  wire logic                    i_ready,
    output logic [4:0]                   o_token_kind,
    output logic [2:0]                   o_func_id,
    output logic [dlt_pkg::VALUE_W-1:0]  o_token_value,
    output logic                         o_last
);
    import dlt_pkg::*;

    // Commands flow from the controller; status flows back from the datapath.
    t_cmd  cmd;
    t_stat stat;

    dlt_ctl u_ctl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    dlt_dp #(
        .MaxTokenChars     (MaxTokenChars),
        .FracBits          (FracBits),
        .MaxFractionDigits (MaxFractionDigits)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_ch           (i_ch),
        .i_end_of_input (i_end_of_input),
        .i_ready        (i_ready),
        .o_valid        (o_valid),
        .o_token_kind   (o_token_kind),
        .o_func_id      (o_func_id),
        .o_token_value  (o_token_value),
        .o_last         (o_last)
    );

endmodule
`default_nettype wire

### dv/tb_drawing_language_tokenizer_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Testbench for the drawing-language tokenizer core
// Feeds directed and random character streams through the input channel and
// compares every output token with a behavioral predictor held in a small
// scoreboard class. Both sides idle at random, with one stretch at full rate.
// ----------------------------------------------------------------------------
module tb_drawing_language_tokenizer_core;
    import dlt_pkg::*;

    typedef struct {
        logic [4:0]         kind;
        logic [2:0]         func;
        logic [VALUE_W-1:0] value;
        logic               last;
    } t_token;

    // Predicts the tokens of each accepted input beat and holds them until
    // they come out of the core in order.
    class token_scoreboard;
        t_token      awaited_q[$];
        int          errors;
        int          tokens_seen;
        t_scan       scan;
        logic [7:0]  name_buf[NAME_DEPTH];
        int          char_cnt;
        bit          point_seen;
        logic [31:0] int_part;
        logic [29:0] frac_part;
        int          frac_cnt;
        string       kw_text[NUM_WORDS];
        logic [4:0]  kw_kind[NUM_WORDS];
        logic [2:0]  kw_func[NUM_WORDS];

        function new();
            kw_text = '{"PI", "E", "T", "SIN", "COS", "TAN", "LOG", "EXP", "SQRT",
                        "ORIGIN", "SCALE", "ROT", "IS", "FOR", "FROM", "TO", "STEP",
                        "DRAW"};
            kw_kind = '{K_CONST, K_CONST, K_PARAM, K_FUNC, K_FUNC, K_FUNC, K_FUNC,
                        K_FUNC, K_FUNC, K_ORIGIN, K_SCALE, K_ROT, K_IS, K_FOR,
                        K_FROM, K_TO, K_STEP, K_DRAW};
            kw_func = '{F_SIN, F_COS, F_SIN, F_SIN, F_COS, F_TAN, F_LOG, F_EXP,
                        F_SQRT, F_SIN, F_SIN, F_SIN, F_SIN, F_SIN, F_SIN, F_SIN,
                        F_SIN, F_SIN};
            scan = SC_START;
            char_cnt = 0;
            point_seen = 0;
            int_part = 0;
            frac_part = 0;
            frac_cnt = 0;
            errors = 0;
            tokens_seen = 0;
        endfunction

        function bit alpha(logic [7:0] c);
            return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
        endfunction

        function bit numeral(logic [7:0] c);
            return c >= "0" && c <= "9";
        endfunction

        function logic [7:0] fold(logic [7:0] c);
            return (c >= "a" && c <= "z") ? c - 8'd32 : c;
        endfunction

        // Unsigned fixed point with 16 fraction bits, truncated toward zero.
        function logic [VALUE_W-1:0] fixed_of(logic [31:0] ip, logic [29:0] fp, int nd);
            logic [63:0] v;
            logic [63:0] div;
            v = {32'd0, ip} << FRAC_BITS_DEF;
            if (nd > 0) begin
                div = 64'd1;
                repeat (nd) div = div * 64'd10;
                v = v + (({34'd0, fp} << FRAC_BITS_DEF) / div);
            end
            return v[VALUE_W-1:0];
        endfunction

        function void add(ref t_token toks[$], input logic [4:0] k,
                          input logic [2:0] f, input logic [VALUE_W-1:0] v);
            t_token t;
            t = '{kind: k, func: f, value: v, last: 1'b0};
            if (toks.size() < 2) toks.push_back(t);
        endfunction

        function void add_word(ref t_token toks[$]);
            bit hit;
            logic [VALUE_W-1:0] v;
            for (int e = 0; e < NUM_WORDS; e++) begin
                if (kw_text[e].len() == char_cnt) begin
                    hit = 1;
                    for (int i = 0; i < char_cnt; i++)
                        if (name_buf[i] != kw_text[e][i]) hit = 0;
                    if (hit) begin
                        v = '0;
                        if (kw_kind[e] == K_CONST)
                            v = (kw_func[e] == F_COS) ? fixed_of(32'd2, 30'd71828, 5)
                                                      : fixed_of(32'd3, 30'd1415926, 7);
                        add(toks, kw_kind[e], (kw_kind[e] == K_FUNC) ? kw_func[e] : 3'd0, v);
                        return;
                    end
                end
            end
            add(toks, K_ERR, 3'd0, '0);
        endfunction

        // A character seen from the start state.
        function void begin_token(logic [7:0] c, ref t_token toks[$]);
            char_cnt = 0;
            point_seen = 0;
            scan = SC_START;
            if (alpha(c)) begin
                name_buf[0] = fold(c);
                char_cnt = 1;
                scan = SC_WORD;
            end else if (numeral(c)) begin
                int_part = {24'd0, 8'(c - "0")};
                frac_part = 0;
                frac_cnt = 0;
                char_cnt = 1;
                scan = SC_NUM;
            end else begin
                case (c)
                    CH_STAR:   scan = SC_STAR;
                    CH_SLASH:  scan = SC_SLASH;
                    CH_MINUS:  scan = SC_MINUS;
                    CH_SEMI:   add(toks, K_SEMI, 3'd0, '0);
                    CH_LPAREN: add(toks, K_LPAREN, 3'd0, '0);
                    CH_RPAREN: add(toks, K_RPAREN, 3'd0, '0);
                    CH_COMMA:  add(toks, K_COMMA, 3'd0, '0);
                    CH_PLUS:   add(toks, K_PLUS, 3'd0, '0);
                    CH_SPACE, CH_TAB, CH_LF, CH_CR: ;
                    default:   add(toks, K_ERR, 3'd0, '0);
                endcase
            end
        endfunction

        function void note_beat(logic [7:0] c, logic eoi);
            t_token toks[$];
            bit redo;
            logic [63:0] wide;
            redo = 0;
            if (eoi) begin
                case (scan)
                    SC_WORD:  add_word(toks);
                    SC_NUM:   add(toks, K_CONST, 3'd0,
                                  fixed_of(int_part, frac_part, frac_cnt));
                    SC_STAR:  add(toks, K_MUL, 3'd0, '0);
                    SC_SLASH: add(toks, K_DIV, 3'd0, '0);
                    SC_MINUS: add(toks, K_MINUS, 3'd0, '0);
                    default: ;
                endcase
                add(toks, K_END, 3'd0, '0);
                scan = SC_START;
                char_cnt = 0;
                point_seen = 0;
            end else begin
                case (scan)
                    SC_WORD: begin
                        if (alpha(c) || numeral(c)) begin
                            if (char_cnt >= MAX_TOKEN_CHARS_DEF) begin
                                add(toks, K_ERR, 3'd0, '0);
                                redo = 1;
                            end else begin
                                if (char_cnt < NAME_DEPTH) name_buf[char_cnt] = fold(c);
                                char_cnt++;
                            end
                        end else begin
                            add_word(toks);
                            redo = 1;
                        end
                    end
                    SC_NUM: begin
                        if (numeral(c) || c == CH_DOT) begin
                            if (c == CH_DOT && point_seen) begin
                                add(toks, K_ERR, 3'd0, '0);
                                scan = SC_START;
                            end else if (char_cnt >= MAX_TOKEN_CHARS_DEF) begin
                                add(toks, K_ERR, 3'd0, '0);
                                redo = 1;
                            end else begin
                                char_cnt++;
                                if (c == CH_DOT) begin
                                    point_seen = 1;
                                end else if (point_seen) begin
                                    if (frac_cnt < MAX_FRACTION_DIGITS_DEF) begin
                                        frac_part = 30'(frac_part * 30'd10 +
                                                        {22'd0, 8'(c - "0")});
                                        frac_cnt++;
                                    end
                                end else begin
                                    wide = {32'd0, int_part} * 64'd10 +
                                           {56'd0, 8'(c - "0")};
                                    int_part = (wide > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF
                                                                      : wide[31:0];
                                end
                            end
                        end else begin
                            add(toks, K_CONST, 3'd0,
                                fixed_of(int_part, frac_part, frac_cnt));
                            redo = 1;
                        end
                    end
                    SC_STAR: begin
                        if (c == CH_STAR) begin
                            add(toks, K_POW, 3'd0, '0);
                            scan = SC_START;
                        end else begin
                            add(toks, K_MUL, 3'd0, '0);
                            redo = 1;
                        end
                    end
                    SC_SLASH: begin
                        if (c == CH_SLASH) scan = SC_COMMENT;
                        else begin
                            add(toks, K_DIV, 3'd0, '0);
                            redo = 1;
                        end
                    end
                    SC_MINUS: begin
                        if (c == CH_MINUS) scan = SC_COMMENT;
                        else begin
                            add(toks, K_MINUS, 3'd0, '0);
                            redo = 1;
                        end
                    end
                    SC_COMMENT: if (c == CH_LF) scan = SC_START;
                    default: redo = 1;
                endcase
                if (redo) begin_token(c, toks);
            end
            if (toks.size() > 0) toks[toks.size() - 1].last = 1'b1;
            foreach (toks[i]) awaited_q.push_back(toks[i]);
        endfunction

        function void check_token(t_token got);
            t_token want;
            tokens_seen++;
            if (awaited_q.size() == 0) begin
                $display("%0t: unexpected token kind=%0d func=%0d value=%h last=%0d",
                         $time, got.kind, got.func, got.value, got.last);
                errors++;
                return;
            end
            want = awaited_q.pop_front();
            if (got.kind != want.kind) begin
                $display("%0t: token_kind expected %0d actual %0d", $time, want.kind, got.kind);
                errors++;
            end
            if (got.func != want.func) begin
                $display("%0t: func_id expected %0d actual %0d", $time, want.func, got.func);
                errors++;
            end
            if (got.value != want.value) begin
                $display("%0t: token_value expected %h actual %h",
                         $time, want.value, got.value);
                errors++;
            end
            if (got.last != want.last) begin
                $display("%0t: last expected %0d actual %0d", $time, want.last, got.last);
                errors++;
            end
        endfunction

        function int pending();
            return awaited_q.size();
        endfunction
    endclass

    localparam int STALL_LIMIT = 3000;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_valid;
    logic                 o_ready;
    logic [7:0]           i_ch;
    logic                 i_end_of_input;
    logic                 o_valid;
    logic                 i_ready;
    logic [4:0]           o_token_kind;
    logic [2:0]           o_func_id;
    logic [VALUE_W-1:0]   o_token_value;
    logic                 o_last;

    token_scoreboard tok_sb;
    int  idle_pct;
    int  beats_sent;
    int  quiet_cycles;
    bit  timed_out;

    drawing_language_tokenizer_core dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_ch           (i_ch),
        .i_end_of_input (i_end_of_input),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_token_kind   (o_token_kind),
        .o_func_id      (o_func_id),
        .o_token_value  (o_token_value),
        .o_last         (o_last)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // The receiver stalls at the same random rate as the sender idles.
    always @(negedge i_clk) begin
        i_ready <= ($urandom_range(99) >= idle_pct);
    end

    // Output beats are checked at the rising edge where they are taken.
    always @(posedge i_clk) begin
        t_token got;
        if (i_rst_n && o_valid && i_ready) begin
            got = '{kind: o_token_kind, func: o_func_id, value: o_token_value,
                    last: o_last};
            tok_sb.check_token(got);
        end
    end

    // Watchdog: a long run of cycles with no beat on either side means a hang.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT && !timed_out) begin
                timed_out = 1;
                $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
                $display("drawing_language_tokenizer_core verification failed");
                $finish;
            end
        end
    end

    // Send one input beat, with a random idle gap first. Valid stays high from
    // one beat to the next when no gap is drawn.
    task automatic send_beat(input logic [7:0] c, input logic eoi);
        while ($urandom_range(99) < idle_pct) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_valid        <= 1'b1;
        i_ch           <= c;
        i_end_of_input <= eoi;
        do @(posedge i_clk); while (!(i_valid && o_ready));
        tok_sb.note_beat(c, eoi);
        beats_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_beat(s[i], 1'b0);
    endtask

    task automatic send_end();
        send_beat(8'($urandom_range(255)), 1'b1);
    endtask

    // Stop offering beats until the core has delivered everything owed.
    task automatic drain();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (tok_sb.pending() != 0) @(posedge i_clk);
    endtask

    function automatic string rand_digits(int n);
        string s;
        s = "";
        repeat (n) s = {s, string'(byte'("0" + $urandom_range(9)))};
        return s;
    endfunction

    // One random fragment of source text: mostly well-formed tokens with random
    // content, some broken ones, comments and white space.
    function automatic string rand_fragment();
        string names[NUM_WORDS];
        string s;
        int    n;
        names = '{"PI", "E", "T", "SIN", "COS", "TAN", "LOG", "EXP", "SQRT",
                  "ORIGIN", "SCALE", "ROT", "IS", "FOR", "FROM", "TO", "STEP", "DRAW"};
        s = "";
        case ($urandom_range(9))
            0, 1, 2: begin
                s = names[$urandom_range(NUM_WORDS - 1)];
                for (int i = 0; i < s.len(); i++)
                    if ($urandom_range(1)) s[i] = s[i] + 8'd32;
            end
            3, 4: begin
                n = ($urandom_range(9) == 0) ? $urandom_range(10, 22) : $urandom_range(1, 6);
                s = rand_digits(n);
                if ($urandom_range(1)) begin
                    n = ($urandom_range(5) == 0) ? $urandom_range(8, 14) : $urandom_range(0, 4);
                    s = {s, ".", rand_digits(n)};
                    if ($urandom_range(9) == 0) s = {s, ".", rand_digits(2)};
                end
            end
            5: begin
                case ($urandom_range(9))
                    0: s = ";";  1: s = "(";  2: s = ")";  3: s = ",";  4: s = "+";
                    5: s = "-";  6: s = "*";  7: s = "/";  default: s = "**";
                endcase
            end
            6: begin
                s = $urandom_range(1) ? "//" : "--";
                repeat ($urandom_range(0, 6)) s = {s, string'(byte'($urandom_range(32, 126)))};
                s = {s, "\n"};
            end
            7: begin
                n = ($urandom_range(4) == 0) ? $urandom_range(7, 24) : $urandom_range(1, 6);
                s = string'(byte'("a" + $urandom_range(25)));
                repeat (n - 1)
                    s = {s, string'(byte'($urandom_range(1) ? "A" + $urandom_range(25)
                                                            : "0" + $urandom_range(9)))};
            end
            8: begin
                case ($urandom_range(3))
                    0: s = " ";  1: s = "\t";  2: s = "\n";  default: s = "\r";
                endcase
            end
            default: s = "";
        endcase
        return s;
    endfunction

    initial begin
        string frag;
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_ch = 8'h00;
        i_end_of_input = 1'b0;
        i_ready = 1'b0;
        idle_pct = 33;
        beats_sent = 0;
        quiet_cycles = 0;
        timed_out = 0;
        tok_sb = new();
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part: every keyword in mixed case, every delimiter and
        // operator, both comment styles, and the corner cases of words and
        // numbers, then end of input with each kind of pending token.
        send_text("PI e t sin COS Tan log EXP sqrt ");
        send_text("origin SCALE rot is for from to step draw ");
        send_text(";(),+-*/**- * / ");
        send_text("// note\n-- more\n");
        send_text("ab1 abcdefg abcdefghijklmnopqrstuvw ");
        send_text("1234567890123456789012 4294967295 4294967296 99999999999 ");
        send_text("0.1234567891234 5. 1.2.3 ");
        send_text("@ . ");
        send_beat(8'hFF, 1'b0);
        send_beat(8'h80, 1'b0);
        send_beat(8'h00, 1'b0);
        send_text("abc");   send_end();
        send_text("12.5");  send_end();
        send_text("*");     send_end();
        send_text("/");     send_end();
        send_text("-");     send_end();
        send_text("// x");  send_end();
        send_end();

        // Hold off until every token owed so far has come out.
        drain();

        // Random part, with a stretch at full rate on both sides.
        while (beats_sent < 1500) begin
            idle_pct = (beats_sent > 700 && beats_sent < 950) ? 0 : 33;
            if ($urandom_range(7) == 0) send_beat(8'($urandom_range(255)), 1'b0);
            else begin
                frag = rand_fragment();
                send_text(frag);
            end
            if ($urandom_range(4) != 0) send_beat(CH_SPACE, 1'b0);
            if ($urandom_range(49) == 0) send_end();
        end
        send_end();
        idle_pct = 33;

        drain();
        repeat (200) @(posedge i_clk);

        $display("Sent %0d input beats, directed and random; checked %0d tokens.",
                 beats_sent, tok_sb.tokens_seen);
        if (tok_sb.errors == 0 && tok_sb.pending() == 0) begin
            $display("drawing_language_tokenizer_core verification clean");
        end else begin
            $display("%0d mismatches, %0d tokens never seen", tok_sb.errors,
                     tok_sb.pending());
            $display("drawing_language_tokenizer_core verification failed");
        end
        $finish;
    end

endmodule
`default_nettype wire

### drawing_language_tokenizer_core.f
design/dlt_pkg.sv
design/dlt_div.sv
design/dlt_dp.sv
design/dlt_ctl.sv
design/drawing_language_tokenizer_core.sv
dv/tb_drawing_language_tokenizer_core.sv
